@@ sv/sct_pkg.sv @@
// shared constants and types for the segment crossing test block
package sct_pkg;

  localparam int unsigned SCT_COORD_BITS  = 16;
  localparam int unsigned SCT_QUEUE_DEPTH = 4;

  localparam logic SCT_MODE_CIRCLE  = 1'b0;
  localparam logic SCT_MODE_SEGMENT = 1'b1;

  // sign of a difference
  typedef struct packed {
    logic neg;
    logic zero;
  } sct_sign_t;

  // per-request decision state carried alongside the wide multiply
  typedef struct packed {
    logic      mode;
    logic      use_end;
    sct_sign_t sb;
    sct_sign_t se;
    logic      seg_hit;
  } sct_flags_t;

endpackage

@@ sv/segment_crossing_test_top.sv @@
// segment crossing test: top level joining front, queue and back pipeline
//
// Each request holds a segment A and either a circle (mode 0) or a second
// segment B (mode 1); the block answers whether the two cross, with exact
// integer arithmetic. One request is taken every clock cycle while the queue
// has room, and one result is delivered every cycle while the output side
// keeps taking them. With no stall, the front register captures a request,
// then it passes one queue slot and six back stages (products, sums, case
// selection, two for the split wide multiply of the circle distance compare,
// and the result register), at whose end its result is valid. The back
// pipeline stalls as a whole on output backpressure; the queue lets the input
// side keep taking requests meanwhile until it is full.
module segment_crossing_test_top #(
  parameter int unsigned COORD_BITS = sct_pkg::SCT_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] seg_a_x,
  input  logic signed [COORD_BITS-1:0] seg_a_y,
  input  logic signed [COORD_BITS-1:0] seg_a_dx,
  input  logic signed [COORD_BITS-1:0] seg_a_dy,
  input  logic signed [COORD_BITS-1:0] other_x,
  input  logic signed [COORD_BITS-1:0] other_y,
  input  logic signed [COORD_BITS-1:0] other_dx,
  input  logic signed [COORD_BITS-1:0] other_dy,
  input  logic        [COORD_BITS-2:0] radius,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         crossed
);

  localparam int unsigned REC_W = 10 * (COORD_BITS + 2) + COORD_BITS + 3;

  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [REC_W-1:0] push_data, pop_data;

  sct_front #(.COORD_BITS(COORD_BITS), .REC_W(REC_W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .seg_a_x    (seg_a_x),
    .seg_a_y    (seg_a_y),
    .seg_a_dx   (seg_a_dx),
    .seg_a_dy   (seg_a_dy),
    .other_x    (other_x),
    .other_y    (other_y),
    .other_dx   (other_dx),
    .other_dy   (other_dy),
    .radius     (radius),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sct_queue #(.WIDTH(REC_W), .DEPTH(sct_pkg::SCT_QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sct_back #(.COORD_BITS(COORD_BITS), .REC_W(REC_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .crossed   (crossed)
  );

endmodule

@@ sv/sct_front.sv @@
// front stage: takes requests, forms coordinate differences and shape flags
module sct_front #(
  parameter int unsigned COORD_BITS = sct_pkg::SCT_COORD_BITS,
  parameter int unsigned REC_W      = 10 * (COORD_BITS + 2) + COORD_BITS + 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] seg_a_x,
  input  logic signed [COORD_BITS-1:0] seg_a_y,
  input  logic signed [COORD_BITS-1:0] seg_a_dx,
  input  logic signed [COORD_BITS-1:0] seg_a_dy,
  input  logic signed [COORD_BITS-1:0] other_x,
  input  logic signed [COORD_BITS-1:0] other_y,
  input  logic signed [COORD_BITS-1:0] other_dx,
  input  logic signed [COORD_BITS-1:0] other_dy,
  input  logic        [COORD_BITS-2:0] radius,
  output logic                         push_valid,
  input  logic                         push_ready,
  output logic [REC_W-1:0]             push_data
);

  localparam int unsigned E = COORD_BITS + 2;

  logic signed [E-1:0] ax, ay, vx, vy, ox, oy, wx, wy;
  logic signed [E-1:0] cx, cy, ex, ey, sx1, sy1;
  logic                az, wz, pz;
  logic                fv;
  logic [REC_W-1:0]    rec;

  assign ax = E'(seg_a_x);
  assign ay = E'(seg_a_y);
  assign vx = E'(seg_a_dx);
  assign vy = E'(seg_a_dy);
  assign ox = E'(other_x);
  assign oy = E'(other_y);
  assign wx = E'(other_dx);
  assign wy = E'(other_dy);

  assign cx  = ox - ax;
  assign cy  = oy - ay;
  assign ex  = vx - cx;
  assign ey  = vy - cy;
  assign sx1 = cx + wx;
  assign sy1 = cy + wy;
  assign az  = (seg_a_dx == '0) && (seg_a_dy == '0);
  assign wz  = (other_dx == '0) && (other_dy == '0);
  assign pz  = (cx == '0) && (cy == '0);

  assign in_ready   = !fv || push_ready;
  assign push_valid = fv;
  assign push_data  = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rec <= {mode, az, wz, pz, radius, vx, vy, wx, wy, cx, cy, ex, ey, sx1, sy1};
    end
  end

endmodule

@@ sv/sct_queue.sv @@
// small fifo between the front and back stages
module sct_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = sct_pkg::SCT_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             push, pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ sv/sct_wide_mul.sv @@
// two-stage unsigned multiplier built from four half-width partial products
module sct_wide_mul #(
  parameter int unsigned W = 37
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);

  localparam int unsigned H = (W + 1) / 2;
  localparam int unsigned L = W - H;

  logic [2*H-1:0] ll;
  logic [H+L-1:0] lh, hl;
  logic [2*L-1:0] hh;

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= a[H-1:0] * b[H-1:0];
      lh <= a[H-1:0] * b[W-1:H];
      hl <= a[W-1:H] * b[H-1:0];
      hh <= a[W-1:H] * b[W-1:H];
      p  <= (2*W)'(ll) + (((2*W)'(lh) + (2*W)'(hl)) << H) + ((2*W)'(hh) << (2*H));
    end
  end

endmodule

@@ sv/sct_back.sv @@
// back pipeline: products, sums, case decisions, exact circle compare, result register
module sct_back #(
  parameter int unsigned COORD_BITS = sct_pkg::SCT_COORD_BITS,
  parameter int unsigned REC_W      = 10 * (COORD_BITS + 2) + COORD_BITS + 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  logic [REC_W-1:0] pop_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             crossed
);

  localparam int unsigned E = COORD_BITS + 2;
  localparam int unsigned M = 2 * E;
  localparam int unsigned P = M + 2;
  localparam int unsigned W = P - 1;

  logic en;
  logic v1, v2, v3, v4, v5;

  // unpacked request
  logic                r_mode, r_az, r_wz, r_pz;
  logic [COORD_BITS-2:0] r_rad;
  logic signed [E-1:0] vx, vy, wx, wy, cx, cy, ex, ey, sx1, sy1, rs;

  assign sy1    = pop_data[E-1:0];
  assign sx1    = pop_data[2*E-1:E];
  assign ey     = pop_data[3*E-1:2*E];
  assign ex     = pop_data[4*E-1:3*E];
  assign cy     = pop_data[5*E-1:4*E];
  assign cx     = pop_data[6*E-1:5*E];
  assign wy     = pop_data[7*E-1:6*E];
  assign wx     = pop_data[8*E-1:7*E];
  assign vy     = pop_data[9*E-1:8*E];
  assign vx     = pop_data[10*E-1:9*E];
  assign r_rad  = pop_data[10*E+COORD_BITS-2:10*E];
  assign r_pz   = pop_data[10*E+COORD_BITS-1];
  assign r_wz   = pop_data[10*E+COORD_BITS];
  assign r_az   = pop_data[10*E+COORD_BITS+1];
  assign r_mode = pop_data[10*E+COORD_BITS+2];
  assign rs     = signed'(E'(r_rad));

  assign en        = !out_valid || out_ready;
  assign pop_ready = en;

  // stage 1: products
  logic              m1, az1, wz1, pz1;
  logic signed [M-1:0] p_vxcx, p_vycy, p_vxvx, p_vyvy, p_rr, p_cxcx, p_cycy;
  logic signed [M-1:0] p_exex, p_eyey, p_vxcy, p_vycx, p_vxwy, p_wxvy, p_wxcy;
  logic signed [M-1:0] p_wycx, p_cxwx, p_cywy, p_wxwx, p_wywy, p_s1x, p_s1y;

  always_ff @(posedge clk) begin
    if (en) begin
      m1     <= r_mode;
      az1    <= r_az;
      wz1    <= r_wz;
      pz1    <= r_pz;
      p_vxcx <= vx * cx;
      p_vycy <= vy * cy;
      p_vxvx <= vx * vx;
      p_vyvy <= vy * vy;
      p_rr   <= rs * rs;
      p_cxcx <= cx * cx;
      p_cycy <= cy * cy;
      p_exex <= ex * ex;
      p_eyey <= ey * ey;
      p_vxcy <= vx * cy;
      p_vycx <= vy * cx;
      p_vxwy <= vx * wy;
      p_wxvy <= wx * vy;
      p_wxcy <= wx * cy;
      p_wycx <= wy * cx;
      p_cxwx <= cx * wx;
      p_cywy <= cy * wy;
      p_wxwx <= wx * wx;
      p_wywy <= wy * wy;
      p_s1x  <= sx1 * vx;
      p_s1y  <= sy1 * vy;
    end
  end

  // stage 2: sums
  logic              m2, az2, wz2, pz2, crossz2;
  logic signed [P-1:0] dot2, sqv2, sqr2, bsq2, esq2, cr2, inc2, mnum2, nnum2;
  logic signed [P-1:0] t2, wl2, s1_2;

  always_ff @(posedge clk) begin
    if (en) begin
      m2      <= m1;
      az2     <= az1;
      wz2     <= wz1;
      pz2     <= pz1;
      crossz2 <= (p_wxcy == p_wycx);
      dot2    <= P'(p_vxcx) + P'(p_vycy);
      sqv2    <= P'(p_vxvx) + P'(p_vyvy);
      sqr2    <= P'(p_rr);
      bsq2    <= P'(p_cxcx) + P'(p_cycy) - P'(p_rr);
      esq2    <= P'(p_exex) + P'(p_eyey) - P'(p_rr);
      cr2     <= P'(p_vxcy) - P'(p_vycx);
      inc2    <= P'(p_vxwy) - P'(p_wxvy);
      mnum2   <= P'(p_wycx) - P'(p_wxcy);
      nnum2   <= P'(p_vycx) - P'(p_vxcy);
      t2      <= -(P'(p_cxwx) + P'(p_cywy));
      wl2     <= P'(p_wxwx) + P'(p_wywy);
      s1_2    <= P'(p_s1x) + P'(p_s1y);
    end
  end

  // stage 3: case selection and flags
  function automatic logic in_unit(input logic signed [P-1:0] num,
                                   input logic signed [P-1:0] den);
    logic r;
    if (den > 0) begin
      r = (num >= 0) && (num <= den);
    end else begin
      r = (num <= 0) && (num >= den);
    end
    return r;
  endfunction

  logic                seg_c;
  logic signed [P-1:0] acr_c;
  sct_pkg::sct_flags_t f3, f4, f5;
  logic [W-1:0]        acr3, sqv3, sqr3;

  always_comb begin
    acr_c = cr2[P-1] ? -cr2 : cr2;
    if (az2) begin
      if (wz2) begin
        seg_c = pz2;
      end else begin
        seg_c = crossz2 && (t2 >= 0) && (t2 <= wl2);
      end
    end else if (inc2 != '0) begin
      seg_c = in_unit(mnum2, inc2) && in_unit(nnum2, inc2);
    end else begin
      // parallel: overlap only when collinear and B not wholly to one side
      seg_c = (cr2 == '0) && !((dot2 < 0) && (s1_2 < 0))
              && !((dot2 > sqv2) && (s1_2 > sqv2));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3.mode    <= m2;
      f3.use_end <= (dot2 < 0) || (dot2 > sqv2) || (sqv2 == '0);
      f3.sb.neg  <= bsq2[P-1];
      f3.sb.zero <= (bsq2 == '0);
      f3.se.neg  <= esq2[P-1];
      f3.se.zero <= (esq2 == '0);
      f3.seg_hit <= seg_c;
      acr3       <= acr_c[W-1:0];
      sqv3       <= sqv2[W-1:0];
      sqr3       <= sqr2[W-1:0];
      f4         <= f3;
      f5         <= f4;
    end
  end

  // stages 4 and 5: exact squared-distance products
  logic [2*W-1:0] cr_sq, lim_sq;

  sct_wide_mul #(.W(W)) u_mul_cr (
    .clk (clk),
    .en  (en),
    .a   (acr3),
    .b   (acr3),
    .p   (cr_sq)
  );

  sct_wide_mul #(.W(W)) u_mul_lim (
    .clk (clk),
    .en  (en),
    .a   (sqv3),
    .b   (sqr3),
    .p   (lim_sq)
  );

  // final decision
  function automatic logic opposite(input sct_pkg::sct_sign_t a,
                                    input sct_pkg::sct_sign_t b);
    return a.zero || b.zero || (a.neg != b.neg);
  endfunction

  sct_pkg::sct_sign_t sn;
  logic               hit;

  always_comb begin
    sn.neg  = (cr_sq < lim_sq);
    sn.zero = (cr_sq == lim_sq);
    if (f5.mode == sct_pkg::SCT_MODE_SEGMENT) begin
      hit = f5.seg_hit;
    end else if (f5.use_end) begin
      hit = opposite(f5.sb, f5.se);
    end else begin
      hit = opposite(sn, f5.sb) || opposite(sn, f5.se);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= pop_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crossed <= hit;
    end
  end

endmodule

@@ verif/segment_crossing_test_top_test.sv @@
// testbench for segment_crossing_test_top: directed table and random queries, known or predicted
module segment_crossing_test_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = sct_pkg::SCT_COORD_BITS;
  localparam int NUM_RANDOM = 1800;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    int mode;
    int ax, ay, adx, ady;
    int ox, oy, odx, ody;
    int rad;
    int known_hit;  // -1: take the predictor's answer
  } query_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = sct_pkg::SCT_MODE_CIRCLE;
  logic signed [CB-1:0] seg_a_x = '0, seg_a_y = '0, seg_a_dx = '0, seg_a_dy = '0;
  logic signed [CB-1:0] other_x = '0, other_y = '0, other_dx = '0, other_dy = '0;
  logic [CB-2:0] radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic crossed;

  int cur_known = -1;
  bit hit_queue[$];
  int fail_count = 0;
  int results_seen = 0;

  segment_crossing_test_top dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic bit signs_disagree(int a, int b);
    return a * b <= 0;
  endfunction

  function automatic bit circle_hit(longint ax, longint ay, longint vx, longint vy,
                                    longint ox, longint oy, longint r);
    longint cx, cy, dot, sqv, sqr, ex, ey, cr, acr;
    int sb, se, sn;
    logic [127:0] lhs, rhs;
    cx = ox - ax;
    cy = oy - ay;
    dot = vx * cx + vy * cy;
    sqv = vx * vx + vy * vy;
    sqr = r * r;
    ex = vx - cx;
    ey = vy - cy;
    sb = sign_of(cx * cx + cy * cy - sqr);
    se = sign_of(ex * ex + ey * ey - sqr);
    if (dot < 0 || dot > sqv || sqv == 0) return signs_disagree(sb, se);
    cr = vx * cy - vy * cx;
    acr = (cr < 0) ? -cr : cr;
    lhs = 128'(acr) * 128'(acr);
    rhs = 128'(sqv) * 128'(sqr);
    sn = (lhs < rhs) ? -1 : ((lhs > rhs) ? 1 : 0);
    return signs_disagree(sn, sb) || signs_disagree(sn, se);
  endfunction

  function automatic bit within_unit(longint num, longint den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  function automatic bit segments_meet(longint ax, longint ay, longint vx, longint vy,
                                       longint bx, longint by, longint wx, longint wy);
    longint dx, dy, inc, t, s0, s1, len;
    dx = bx - ax;
    dy = by - ay;
    inc = vx * wy - wx * vy;
    if (vx == 0 && vy == 0) begin
      if (wx == 0 && wy == 0) return dx == 0 && dy == 0;
      if (wx * dy != wy * dx) return 1'b0;
      t = -(dx * wx + dy * wy);
      return t >= 0 && t <= wx * wx + wy * wy;
    end
    if (inc != 0)
      return within_unit(wy * dx - wx * dy, inc) && within_unit(vy * dx - vx * dy, inc);
    if (vx * dy != dx * vy) return 1'b0;
    s0 = dx * vx + dy * vy;
    s1 = (dx + wx) * vx + (dy + wy) * vy;
    len = vx * vx + vy * vy;
    return !(s0 < 0 && s1 < 0) && !(s0 > len && s1 > len);
  endfunction

  function automatic bit predict_crossing();
    if (mode == sct_pkg::SCT_MODE_SEGMENT)
      return segments_meet(seg_a_x, seg_a_y, seg_a_dx, seg_a_dy,
                           other_x, other_y, other_dx, other_dy);
    return circle_hit(seg_a_x, seg_a_y, seg_a_dx, seg_a_dy,
                      other_x, other_y, longint'({1'b0, radius}));
  endfunction

  // request monitor: record the expected answer when a request is taken
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      if (cur_known >= 0) hit_queue.push_back(cur_known[0]);
      else hit_queue.push_back(predict_crossing());
    end
  end

  // result monitor
  always @(posedge clk) begin
    bit want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (hit_queue.size() == 0) begin
        $display("%0t: unexpected result crossed=%0b", $realtime, crossed);
        fail_count++;
      end else begin
        want = hit_queue.pop_front();
        if (crossed !== want) begin
          $display("%0t: crossed mismatch expected %0b actual %0b", $realtime, want, crossed);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold to fill the queue
  initial begin
    int n;
    bit long_done;
    long_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = $urandom_range(0, 7);
      if (!long_done && results_seen >= 300) begin
        n = HOLD_CYCLES;
        long_done = 1'b1;
      end
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_query(query_row_t q);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode = q.mode[0];
    seg_a_x = CB'(q.ax);  seg_a_y = CB'(q.ay);
    seg_a_dx = CB'(q.adx); seg_a_dy = CB'(q.ady);
    other_x = CB'(q.ox);  other_y = CB'(q.oy);
    other_dx = CB'(q.odx); other_dy = CB'(q.ody);
    radius = (CB-1)'(q.rad);
    cur_known = q.known_hit;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic int coord_full();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int coord_near(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic query_row_t random_query();
    query_row_t q;
    int kind, k, j;
    kind = $urandom_range(0, 9);
    q.known_hit = -1;
    q.mode = $urandom_range(0, 1);
    if (kind <= 2) begin
      q.ax = coord_full(); q.ay = coord_full(); q.adx = coord_full(); q.ady = coord_full();
      q.ox = coord_full(); q.oy = coord_full(); q.odx = coord_full(); q.ody = coord_full();
      q.rad = $urandom_range(0, 32767);
    end else begin
      q.ax = coord_near(100); q.ay = coord_near(100);
      q.adx = coord_near(100); q.ady = coord_near(100);
      q.ox = coord_near(100); q.oy = coord_near(100);
      q.odx = coord_near(100); q.ody = coord_near(100);
      q.rad = $urandom_range(0, 150);
      k = coord_near(3);
      j = coord_near(3);
      case (kind)
        7: begin  // collinear B
          q.mode = sct_pkg::SCT_MODE_SEGMENT;
          q.adx = coord_near(20); q.ady = coord_near(20);
          q.ox = q.ax + j * q.adx; q.oy = q.ay + j * q.ady;
          q.odx = k * q.adx; q.ody = k * q.ady;
        end
        8: begin  // parallel B, possibly offset
          q.mode = sct_pkg::SCT_MODE_SEGMENT;
          q.odx = k * q.adx; q.ody = k * q.ady;
        end
        9: begin  // zero-length A or B
          if ($urandom_range(0, 1)) begin
            q.adx = 0; q.ady = 0;
          end else begin
            q.odx = 0; q.ody = 0;
          end
          if ($urandom_range(0, 1)) begin
            q.ox = q.ax + coord_near(2); q.oy = q.ay + coord_near(2);
          end
        end
        default: ;
      endcase
    end
    return q;
  endfunction

  query_row_t directed_rows [16] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1},              // everything zero
    '{0, 0, 0, 0, 0, 3, 0, 0, 0, 3, 1},              // zero-length A on the boundary
    '{0, 0, 0, 0, 0, 3, 0, 0, 0, 2, 0},              // zero-length A outside
    '{0, -10, 0, 20, 0, 0, 0, 7, -7, 5, 1},          // chord through the centre
    '{0, -1, 0, 2, 0, 0, 0, 0, 0, 10, 0},            // segment wholly inside
    '{1, 0, 0, 10, 10, 0, 10, 10, -10, 0, 1},        // crossing diagonals
    '{1, 0, 0, 10, 0, 0, 1, 10, 0, 0, 0},            // parallel, apart
    '{1, 0, 0, 10, 0, 5, 0, 10, 0, 0, 1},            // collinear overlap
    '{1, 0, 0, 10, 0, 20, 0, 5, 0, 0, 0},            // collinear beyond the end
    '{1, 0, 0, 10, 0, -9, 0, 5, 0, 0, 0},            // collinear before the start
    '{1, 5, 0, 0, 0, 0, 0, 10, 0, 0, 1},             // point on B
    '{1, 3, 3, 0, 0, 3, 3, 0, 0, 0, 1},              // two coinciding points
    '{1, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0, -1},
    '{0, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, -1},
    '{0, -32768, 32767, 32767, -32768, 32767, -32768, -32768, 32767, 32767, -1},
    '{1, 32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768, 16384, -1}
  };

  // sender
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed_rows[i]) send_query(directed_rows[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 1000) begin
        in_valid = 1'b0;
        while (hit_queue.size() != 0) @(negedge clk);
      end
      send_query(random_query());
    end
    in_valid = 1'b0;
    while (hit_queue.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (hit_queue.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
